@@ hdl/cpw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpw_pkg
// Shared constants, beat types and the arctangent table of the cone weight.
// ----------------------------------------------------------------------------
package cpw_pkg;

    localparam int ANGLE_ITERATIONS = 16;
    localparam int SQRT_STEPS       = 32;
    localparam int DIV_STEPS        = 17;

    localparam int XY_W   = 40;
    localparam int Z_W    = 32;
    localparam int F_W    = 28;
    localparam int ENV_W  = 17;
    localparam int NUM_W  = F_W + ENV_W;

    // degrees scaled by 2^20
    localparam logic signed [Z_W-1:0] DEG_0   = 32'sd0;
    localparam logic signed [Z_W-1:0] DEG_90  = 32'sd94371840;
    localparam logic signed [Z_W-1:0] DEG_180 = 32'sd188743680;
    localparam logic [ENV_W-1:0]      ENV_ONE = 17'd65536;

    typedef struct packed {
        logic             present;
        logic [ENV_W-1:0] env;
        logic [F_W-1:0]   f;
    } side_t;

    typedef struct packed {
        logic [63:0]                v;
        logic [33:0]                rem;
        logic [31:0]                root;
        logic signed [XY_W-1:0]     y;
        logic signed [Z_W-1:0]      z;
        side_t                      side;
    } sqrt_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        side_t                  side;
    } cordic_t;

    typedef struct packed {
        logic [F_W-1:0]   rem;
        logic [ENV_W-1:0] nb;
        logic [ENV_W-1:0] q;
        logic [F_W-1:0]   f;
        logic             forced;
    } div_t;

    // atan(2^-i) in degrees * 2^20
    function automatic logic [26:0] atan_deg(input logic [4:0] i);
        logic [26:0] r;
        begin
            case (i)
                5'd0:    r = 27'd47185920;
                5'd1:    r = 27'd27855475;
                5'd2:    r = 27'd14718068;
                5'd3:    r = 27'd7471121;
                5'd4:    r = 27'd3750058;
                5'd5:    r = 27'd1876857;
                5'd6:    r = 27'd938658;
                5'd7:    r = 27'd469357;
                5'd8:    r = 27'd234682;
                5'd9:    r = 27'd117342;
                5'd10:   r = 27'd58671;
                5'd11:   r = 27'd29335;
                5'd12:   r = 27'd14668;
                5'd13:   r = 27'd7334;
                5'd14:   r = 27'd3667;
                5'd15:   r = 27'd1833;
                5'd16:   r = 27'd917;
                5'd17:   r = 27'd458;
                5'd18:   r = 27'd229;
                5'd19:   r = 27'd115;
                5'd20:   r = 27'd57;
                5'd21:   r = 27'd29;
                5'd22:   r = 27'd14;
                5'd23:   r = 27'd7;
                5'd24:   r = 27'd4;
                5'd25:   r = 27'd2;
                5'd26:   r = 27'd1;
                default: r = 27'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] a);
        logic [32:0] r;
        begin
            r = a[32] ? 33'(-a) : 33'(a);
            return r;
        end
    endfunction

endpackage

@@ hdl/cpw_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpw_if
// Valid/ready channels for target beats and weight beats.
// ----------------------------------------------------------------------------
interface cpw_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] base_z;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic [16:0]        envelope;
    logic [15:0]        falloff_degrees;
    logic               target_present;

    modport source (
        output valid, base_x, base_y, base_z, pose_x, pose_y, pose_z,
               target_x, target_y, target_z, envelope, falloff_degrees, target_present,
        input  ready
    );
    modport sink (
        input  valid, base_x, base_y, base_z, pose_x, pose_y, pose_z,
               target_x, target_y, target_z, envelope, falloff_degrees, target_present,
        output ready
    );
endinterface

interface cpw_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] weight;

    modport source (output valid, weight, input ready);
    modport sink (input valid, weight, output ready);
endinterface

@@ hdl/cone_pose_weight.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cone_pose_weight
// Cone falloff weight of one target from the angle between pose and target.
// ----------------------------------------------------------------------------
// Fully pipelined: one target beat is taken every cycle while the pipe is not
// stalled. Each weight beat passes through the front stages S0 to S7
// (differencing, scaling and cross/dot products), a 32-cell square-root chain,
// one CORDIC cell per angle iteration, the falloff setup stages P1 and P2, a
// 17-cell divide chain and the output register. The whole pipe stalls only
// while a weight beat waits at the output.
module cone_pose_weight (
    input  logic          clk,
    input  logic          rst_n,
    cpw_in_if.sink        in_ch,
    cpw_out_if.source     out_ch
);

    localparam int NI = cpw_pkg::ANGLE_ITERATIONS;
    localparam int NS = cpw_pkg::SQRT_STEPS;
    localparam int ND = cpw_pkg::DIV_STEPS;

    logic en;
    logic out_valid_reg;
    logic [16:0] weight_reg;

    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // front stage valids
    logic [7:0] fv_reg;

    // S0: difference vectors
    logic signed [32:0] s0_u_reg [3];
    logic signed [32:0] s0_w_reg [3];
    cpw_pkg::side_t     s0_side_reg;
    logic [16:0]        env_sat;

    assign env_sat = (in_ch.envelope > cpw_pkg::ENV_ONE) ? cpw_pkg::ENV_ONE : in_ch.envelope;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= '0;
        else if (en)
            fv_reg <= {fv_reg[6:0], in_ch.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_u_reg[0] <= 33'(in_ch.pose_x) - 33'(in_ch.base_x);
            s0_u_reg[1] <= 33'(in_ch.pose_y) - 33'(in_ch.base_y);
            s0_u_reg[2] <= 33'(in_ch.pose_z) - 33'(in_ch.base_z);
            s0_w_reg[0] <= 33'(in_ch.target_x) - 33'(in_ch.base_x);
            s0_w_reg[1] <= 33'(in_ch.target_y) - 33'(in_ch.base_y);
            s0_w_reg[2] <= 33'(in_ch.target_z) - 33'(in_ch.base_z);
            s0_side_reg <= '{present: in_ch.target_present, env: env_sat,
                             f: {in_ch.falloff_degrees, 12'b0}};
        end
    end

    // S1: largest magnitude of each vector
    logic signed [32:0] s1_u_reg [3];
    logic signed [32:0] s1_w_reg [3];
    logic [32:0]        s1_mu_reg;
    logic [32:0]        s1_mw_reg;
    cpw_pkg::side_t     s1_side_reg;
    logic [32:0]        mu_next;
    logic [32:0]        mw_next;

    always_comb
    begin
        mu_next = cpw_pkg::mag33(s0_u_reg[0]);
        mw_next = cpw_pkg::mag33(s0_w_reg[0]);
        for (int k = 1; k < 3; k++)
        begin
            if (cpw_pkg::mag33(s0_u_reg[k]) > mu_next)
                mu_next = cpw_pkg::mag33(s0_u_reg[k]);
            if (cpw_pkg::mag33(s0_w_reg[k]) > mw_next)
                mw_next = cpw_pkg::mag33(s0_w_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_u_reg    <= s0_u_reg;
            s1_w_reg    <= s0_w_reg;
            s1_mu_reg   <= mu_next;
            s1_mw_reg   <= mw_next;
            s1_side_reg <= s0_side_reg;
        end
    end

    // S2: shift amounts that put the largest magnitude in [2^14, 2^15)
    logic signed [32:0] s2_u_reg [3];
    logic signed [32:0] s2_w_reg [3];
    logic [4:0]         s2_ru_reg, s2_rw_reg;
    logic [3:0]         s2_lu_reg, s2_lw_reg;
    cpw_pkg::side_t     s2_side_reg;
    logic [5:0]         blu, blw;
    logic [4:0]         ru_next, rw_next;
    logic [3:0]         lu_next, lw_next;

    always_comb
    begin
        blu = '0;
        blw = '0;
        for (int b = 0; b < 33; b++)
        begin
            if (s1_mu_reg[b])
                blu = 6'(b + 1);
            if (s1_mw_reg[b])
                blw = 6'(b + 1);
        end
        ru_next = (blu > 6'd15) ? 5'(blu - 6'd15) : 5'd0;
        lu_next = (blu > 6'd15) ? 4'd0 : 4'(6'd15 - blu);
        rw_next = (blw > 6'd15) ? 5'(blw - 6'd15) : 5'd0;
        lw_next = (blw > 6'd15) ? 4'd0 : 4'(6'd15 - blw);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_u_reg    <= s1_u_reg;
            s2_w_reg    <= s1_w_reg;
            s2_ru_reg   <= ru_next;
            s2_lu_reg   <= lu_next;
            s2_rw_reg   <= rw_next;
            s2_lw_reg   <= lw_next;
            s2_side_reg <= s1_side_reg;
        end
    end

    // S3: scaled components, right shifts floor
    logic signed [16:0] s3_u_reg [3];
    logic signed [16:0] s3_w_reg [3];
    cpw_pkg::side_t     s3_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s3_u_reg[k] <= 17'((s2_u_reg[k] >>> s2_ru_reg) <<< s2_lu_reg);
                s3_w_reg[k] <= 17'((s2_w_reg[k] >>> s2_rw_reg) <<< s2_lw_reg);
            end
            s3_side_reg <= s2_side_reg;
        end
    end

    // S4: products
    logic signed [33:0] s4_p_reg [9];
    cpw_pkg::side_t     s4_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_p_reg[0] <= s3_u_reg[1] * s3_w_reg[2];
            s4_p_reg[1] <= s3_u_reg[2] * s3_w_reg[1];
            s4_p_reg[2] <= s3_u_reg[2] * s3_w_reg[0];
            s4_p_reg[3] <= s3_u_reg[0] * s3_w_reg[2];
            s4_p_reg[4] <= s3_u_reg[0] * s3_w_reg[1];
            s4_p_reg[5] <= s3_u_reg[1] * s3_w_reg[0];
            s4_p_reg[6] <= s3_u_reg[0] * s3_w_reg[0];
            s4_p_reg[7] <= s3_u_reg[1] * s3_w_reg[1];
            s4_p_reg[8] <= s3_u_reg[2] * s3_w_reg[2];
            s4_side_reg <= s3_side_reg;
        end
    end

    // S5: cross and dot
    logic signed [33:0] s5_c_reg [3];
    logic signed [35:0] s5_dot_reg;
    cpw_pkg::side_t     s5_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_c_reg[0] <= s4_p_reg[0] - s4_p_reg[1];
            s5_c_reg[1] <= s4_p_reg[2] - s4_p_reg[3];
            s5_c_reg[2] <= s4_p_reg[4] - s4_p_reg[5];
            s5_dot_reg  <= 36'(s4_p_reg[6]) + 36'(s4_p_reg[7]) + 36'(s4_p_reg[8]);
            s5_side_reg <= s4_side_reg;
        end
    end

    // S6: squares of the cross components
    logic [63:0]        s6_sq_reg [3];
    logic signed [35:0] s6_dot_reg;
    cpw_pkg::side_t     s6_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                s6_sq_reg[k] <= 64'(s5_c_reg[k]) * 64'(s5_c_reg[k]);
            s6_dot_reg  <= s5_dot_reg;
            s6_side_reg <= s5_side_reg;
        end
    end

    // S7: squared cross length; parallel or null vectors get a fixed angle with y at zero
    cpw_pkg::sqrt_t s7_next;
    cpw_pkg::sqrt_t sq_d [NS+1];
    logic           sq_v [NS+1];

    always_comb
    begin
        s7_next.v    = s6_sq_reg[0] + s6_sq_reg[1] + s6_sq_reg[2];
        s7_next.rem  = '0;
        s7_next.root = '0;
        s7_next.side = s6_side_reg;
        if (s7_next.v == '0)
        begin
            s7_next.y = '0;
            if (s6_dot_reg > 0)
                s7_next.z = cpw_pkg::DEG_0;
            else if (s6_dot_reg < 0)
                s7_next.z = cpw_pkg::DEG_180;
            else
                s7_next.z = cpw_pkg::DEG_90;
        end
        else
        begin
            s7_next.y = -cpw_pkg::XY_W'(s6_dot_reg);
            s7_next.z = cpw_pkg::DEG_90;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sq_d[0] <= s7_next;
    end

    assign sq_v[0] = fv_reg[7];

    for (genvar k = 0; k < NS; k++)
    begin : g_sqrt
        cpw_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_v[k]),
            .in_data   (sq_d[k]),
            .out_valid (sq_v[k+1]),
            .out_data  (sq_d[k+1])
        );
    end

    cpw_pkg::cordic_t co_d [NI+1];
    logic             co_v [NI+1];

    assign co_d[0].x    = cpw_pkg::XY_W'(sq_d[NS].root);
    assign co_d[0].y    = sq_d[NS].y;
    assign co_d[0].z    = sq_d[NS].z;
    assign co_d[0].side = sq_d[NS].side;
    assign co_v[0]      = sq_v[NS];

    for (genvar k = 0; k < NI; k++)
    begin : g_cordic
        cpw_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .step      (5'(k)),
            .in_valid  (co_v[k]),
            .in_data   (co_d[k]),
            .out_valid (co_v[k+1]),
            .out_data  (co_d[k+1])
        );
    end

    // P1: clamp angle and settle the cases that need no divide
    logic                      p1_vld_reg;
    logic                      p1_forced_reg;
    logic [16:0]               p1_fval_reg;
    logic [cpw_pkg::F_W-1:0]   p1_diff_reg;
    logic [16:0]               p1_env_reg;
    logic [cpw_pkg::F_W-1:0]   p1_f_reg;
    logic [cpw_pkg::F_W-1:0]   alpha;
    logic                      forced_next;
    logic [16:0]               fval_next;
    cpw_pkg::side_t            cs;

    always_comb
    begin
        cs = co_d[NI].side;
        if (co_d[NI].z < 0)
            alpha = '0;
        else if (co_d[NI].z > cpw_pkg::DEG_180)
            alpha = cpw_pkg::F_W'(cpw_pkg::DEG_180);
        else
            alpha = cpw_pkg::F_W'(co_d[NI].z);
        forced_next = 1'b1;
        fval_next   = '0;
        if (!cs.present)
            fval_next = '0;
        else if (cs.f == '0)
            fval_next = (alpha == '0) ? cs.env : 17'd0;
        else if (alpha >= cs.f)
            fval_next = '0;
        else
            forced_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_vld_reg <= 1'b0;
        else if (en)
            p1_vld_reg <= co_v[NI];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_forced_reg <= forced_next;
            p1_fval_reg   <= fval_next;
            p1_diff_reg   <= cs.f - alpha;
            p1_env_reg    <= cs.env;
            p1_f_reg      <= cs.f;
        end
    end

    // P2: numerator; its high part is already below the divisor
    cpw_pkg::div_t dv_d [ND+1];
    logic          dv_v [ND+1];
    logic [cpw_pkg::NUM_W-1:0] num;

    assign num = cpw_pkg::NUM_W'(p1_env_reg) * cpw_pkg::NUM_W'(p1_diff_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v[0] <= 1'b0;
        else if (en)
            dv_v[0] <= p1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_d[0].rem    <= num[cpw_pkg::NUM_W-1:cpw_pkg::ENV_W];
            dv_d[0].nb     <= num[cpw_pkg::ENV_W-1:0];
            dv_d[0].q      <= p1_forced_reg ? p1_fval_reg : 17'd0;
            dv_d[0].f      <= p1_f_reg;
            dv_d[0].forced <= p1_forced_reg;
        end
    end

    for (genvar k = 0; k < ND; k++)
    begin : g_div
        cpw_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_v[k]),
            .in_data   (dv_d[k]),
            .out_valid (dv_v[k+1]),
            .out_data  (dv_d[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_v[ND];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            weight_reg <= dv_d[ND].q;
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.weight = weight_reg;

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> weight_reg <= cpw_pkg::ENV_ONE)
        else $error("weight above 1.0");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dv_v[ND] && !dv_d[ND].forced |-> dv_d[ND].rem < dv_d[ND].f)
        else $error("divide remainder not below divisor");

    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        en && co_v[NI] && !co_d[NI].side.present |=> p1_forced_reg && p1_fval_reg == 17'd0)
        else $error("absent target not forced to zero");

endmodule

@@ hdl/cpw_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpw_sqrt_cell
// One root digit of the integer square root; two radicand bits per cell.
// ----------------------------------------------------------------------------
module cpw_sqrt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  cpw_pkg::sqrt_t  in_data,
    output logic            out_valid,
    output cpw_pkg::sqrt_t  out_data
);

    logic           out_valid_reg;
    cpw_pkg::sqrt_t out_data_reg;
    cpw_pkg::sqrt_t out_data_next;
    logic [33:0]    rem_shift;
    logic [33:0]    trial;

    always_comb
    begin
        out_data_next   = in_data;
        rem_shift       = {in_data.rem[31:0], in_data.v[63:62]};
        trial           = {in_data.root, 2'b01};
        out_data_next.v = {in_data.v[61:0], 2'b00};
        if (rem_shift >= trial)
        begin
            out_data_next.rem  = rem_shift - trial;
            out_data_next.root = {in_data.root[30:0], 1'b1};
        end
        else
        begin
            out_data_next.rem  = rem_shift;
            out_data_next.root = {in_data.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hdl/cpw_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpw_cordic_cell
// One vectoring rotation; a vector with y at zero passes unchanged.
// ----------------------------------------------------------------------------
module cpw_cordic_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [4:0]        step,
    input  logic              in_valid,
    input  cpw_pkg::cordic_t  in_data,
    output logic              out_valid,
    output cpw_pkg::cordic_t  out_data
);

    logic                               out_valid_reg;
    cpw_pkg::cordic_t                   out_data_reg;
    cpw_pkg::cordic_t                   out_data_next;
    logic signed [cpw_pkg::XY_W-1:0]    xs;
    logic signed [cpw_pkg::XY_W-1:0]    ys;
    logic signed [cpw_pkg::Z_W-1:0]     az;

    always_comb
    begin
        out_data_next = in_data;
        xs = in_data.x >>> step;
        ys = in_data.y >>> step;
        az = $signed({5'b0, cpw_pkg::atan_deg(step)});
        if (in_data.y > 0)
        begin
            out_data_next.x = in_data.x + ys;
            out_data_next.y = in_data.y - xs;
            out_data_next.z = in_data.z + az;
        end
        else if (in_data.y < 0)
        begin
            out_data_next.x = in_data.x - ys;
            out_data_next.y = in_data.y + xs;
            out_data_next.z = in_data.z - az;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hdl/cpw_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpw_div_cell
// One quotient bit of a restoring divide; forced results pass unchanged.
// ----------------------------------------------------------------------------
module cpw_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  cpw_pkg::div_t  in_data,
    output logic           out_valid,
    output cpw_pkg::div_t  out_data
);

    logic                       out_valid_reg;
    cpw_pkg::div_t              out_data_reg;
    cpw_pkg::div_t              out_data_next;
    logic [cpw_pkg::F_W:0]      t;

    always_comb
    begin
        out_data_next = in_data;
        t = {in_data.rem, in_data.nb[cpw_pkg::ENV_W-1]};
        if (!in_data.forced)
        begin
            out_data_next.nb = {in_data.nb[cpw_pkg::ENV_W-2:0], 1'b0};
            if (t >= {1'b0, in_data.f})
            begin
                out_data_next.rem = cpw_pkg::F_W'(t - {1'b0, in_data.f});
                out_data_next.q   = {in_data.q[cpw_pkg::ENV_W-2:0], 1'b1};
            end
            else
            begin
                out_data_next.rem = t[cpw_pkg::F_W-1:0];
                out_data_next.q   = {in_data.q[cpw_pkg::ENV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ verif/cone_pose_weight_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cone_pose_weight_tb
// Self-checking bench: random and directed target beats, a bit-exact weight
// predictor in a small scoreboard, random idling on both channels.
// ----------------------------------------------------------------------------
module cone_pose_weight_tb;

    localparam int N_RANDOM    = 1100;
    localparam int LATENCY     = 60 + cpw_pkg::ANGLE_ITERATIONS;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] b [3];
        logic signed [31:0] p [3];
        logic signed [31:0] t [3];
        logic [16:0]        env;
        logic [15:0]        fall;
        logic               present;
    } target_beat_t;

    logic clk;
    logic rst_n;
    int   n_errors;
    int   cycles;
    bit   calm;

    cpw_in_if  in_ch ();
    cpw_out_if out_ch ();

    cone_pose_weight u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint absl(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit normalize(ref longint c [3]);
        longint m;
        m = absl(c[0]);
        if (absl(c[1]) > m) m = absl(c[1]);
        if (absl(c[2]) > m) m = absl(c[2]);
        if (m == 0) return 0;
        while (m >= (64'sd1 <<< 15))
        begin
            for (int k = 0; k < 3; k++) c[k] = c[k] >>> 1;
            m = m >>> 1;
        end
        while (m < (64'sd1 <<< 14))
        begin
            for (int k = 0; k < 3; k++) c[k] = c[k] * 2;
            m = m * 2;
        end
        return 1;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint atan_tab(input int i);
        longint tab [27] = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
            938658, 469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
            917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
        return i < 27 ? tab[i] : 0;
    endfunction

    function automatic longint cone_angle(ref longint u [3], ref longint v [3]);
        longint cx, cy, cz, dot, x, y, z, nx, ny;
        longint unsigned sq;
        if (!normalize(u) || !normalize(v)) return longint'(cpw_pkg::DEG_90);
        cx  = u[1] * v[2] - u[2] * v[1];
        cy  = u[2] * v[0] - u[0] * v[2];
        cz  = u[0] * v[1] - u[1] * v[0];
        dot = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
        sq  = cx * cx + cy * cy + cz * cz;
        if (sq == 0)
        begin
            if (dot > 0) return 0;
            if (dot < 0) return longint'(cpw_pkg::DEG_180);
            return longint'(cpw_pkg::DEG_90);
        end
        x = longint'(int_sqrt(sq));
        y = -dot;
        z = longint'(cpw_pkg::DEG_90);
        for (int i = 0; i < cpw_pkg::ANGLE_ITERATIONS; i++)
        begin
            if (y == 0) break;
            if (y > 0)
            begin
                nx = x + floor_shr(y, i);
                ny = y - floor_shr(x, i);
                z  = z + longint'(atan_tab(i));
            end
            else
            begin
                nx = x - floor_shr(y, i);
                ny = y + floor_shr(x, i);
                z  = z - longint'(atan_tab(i));
            end
            x = nx;
            y = ny;
        end
        if (z < 0) z = 0;
        if (z > longint'(cpw_pkg::DEG_180)) z = longint'(cpw_pkg::DEG_180);
        return z;
    endfunction

    function automatic logic [16:0] predict_weight(input target_beat_t tb);
        longint u [3];
        longint v [3];
        longint alpha, f, env;
        env = tb.env > 17'd65536 ? 65536 : longint'(tb.env);
        f   = longint'(tb.fall) <<< 12;
        if (!tb.present) return '0;
        for (int k = 0; k < 3; k++)
        begin
            u[k] = longint'(tb.p[k]) - longint'(tb.b[k]);
            v[k] = longint'(tb.t[k]) - longint'(tb.b[k]);
        end
        alpha = cone_angle(u, v);
        if (f == 0) return alpha == 0 ? 17'(env) : '0;
        if (alpha >= f) return '0;
        return 17'((env * (f - alpha)) / f);
    endfunction

    class weight_scoreboard;
        logic [16:0] pending [$];
        int          n_checked;

        function void note_target(input target_beat_t tb);
            pending = {pending, predict_weight(tb)};
        endfunction

        task check_weight(input logic [16:0] got);
            logic [16:0] want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected weight beat %0d", got));
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got !== want)
                report($sformatf("weight got %0d want %0d", got, want));
        endtask
    endclass

    weight_scoreboard sb = new();
    target_beat_t     stim [$];

    task automatic queue_beat(input target_beat_t tb);
        stim = {stim, tb};
    endtask

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles", cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] rnd_coord(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 8000)) - 4000;
            2: return $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
            default: return ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
        endcase
    endfunction

    function automatic target_beat_t random_beat();
        target_beat_t tb;
        int mode;
        mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 9) == 0 ? 3 :
               $urandom_range(1, 2));
        for (int k = 0; k < 3; k++)
        begin
            tb.b[k] = rnd_coord(mode);
            tb.p[k] = rnd_coord(mode);
            tb.t[k] = rnd_coord(mode);
        end
        // occasional degenerate geometry: coincident or parallel directions
        case ($urandom_range(0, 19))
            0: tb.p = tb.b;
            1: tb.t = tb.b;
            2: tb.t = tb.p;
            3: for (int k = 0; k < 3; k++) tb.t[k] = 2 * tb.b[k] - tb.p[k];
            default: ;
        endcase
        tb.env     = $urandom_range(0, 9) == 0 ? 17'($urandom) : 17'($urandom_range(0, 65536));
        tb.fall    = $urandom_range(0, 9) == 0 ? 16'($urandom) :
                     ($urandom_range(0, 19) == 0 ? 16'd0 : 16'($urandom_range(1, 46080)));
        tb.present = $urandom_range(0, 9) != 0;
        return tb;
    endfunction

    function automatic target_beat_t mk(input int px, py, pz, tx, ty, tz,
                                         input int env, fall, pres);
        target_beat_t tb;
        tb.b = '{0, 0, 0};
        tb.p = '{px, py, pz};
        tb.t = '{tx, ty, tz};
        tb.env = 17'(env);
        tb.fall = 16'(fall);
        tb.present = pres[0];
        return tb;
    endfunction

    task automatic drive_targets();
        target_beat_t tb;
        int idx;
        bit hold;
        idx  = 0;
        hold = 0;
        while (idx < stim.size())
        begin
            tb = stim[idx];
            // an offered beat keeps valid until it is taken
            if (!hold)
                in_ch.valid <= calm || $urandom_range(0, 99) >= 17;
            in_ch.base_x          <= tb.b[0];
            in_ch.base_y          <= tb.b[1];
            in_ch.base_z          <= tb.b[2];
            in_ch.pose_x          <= tb.p[0];
            in_ch.pose_y          <= tb.p[1];
            in_ch.pose_z          <= tb.p[2];
            in_ch.target_x        <= tb.t[0];
            in_ch.target_y        <= tb.t[1];
            in_ch.target_z        <= tb.t[2];
            in_ch.envelope        <= tb.env;
            in_ch.falloff_degrees <= tb.fall;
            in_ch.target_present  <= tb.present;
            @(posedge clk);
            hold = in_ch.valid && !in_ch.ready;
            if (in_ch.valid && in_ch.ready)
            begin
                sb.note_target(tb);
                idx++;
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready) sb.check_weight(out_ch.weight);
            out_ch.ready <= calm || $urandom_range(0, 99) >= 17;
        end
    end

    initial
    begin
        n_errors = 0;
        calm = 0;
        rst_n = 0;
        in_ch.valid = 0;
        in_ch.base_x = 0; in_ch.base_y = 0; in_ch.base_z = 0;
        in_ch.pose_x = 0; in_ch.pose_y = 0; in_ch.pose_z = 0;
        in_ch.target_x = 0; in_ch.target_y = 0; in_ch.target_z = 0;
        in_ch.envelope = 0; in_ch.falloff_degrees = 0; in_ch.target_present = 0;
        out_ch.ready = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;

        // directed: same/opposite/orthogonal directions, zero vectors, absent
        // target, zero and over-range falloff, envelope above one, extremes
        queue_beat(mk(100, 0, 0, 200, 0, 0, 65536, 46080, 1));
        queue_beat(mk(100, 0, 0, -200, 0, 0, 65536, 46080, 1));
        queue_beat(mk(100, 0, 0, 0, 300, 0, 65536, 46080, 1));
        queue_beat(mk(0, 0, 0, 5, 5, 5, 65536, 46080, 1));
        queue_beat(mk(7, 8, 9, 0, 0, 0, 40000, 23040, 1));
        queue_beat(mk(100, 0, 0, 200, 0, 0, 50000, 0, 1));
        queue_beat(mk(100, 0, 0, 100, 1, 0, 50000, 0, 1));
        queue_beat(mk(100, 20, 0, 100, 0, 30, 131071, 65535, 1));
        queue_beat(mk(100, 20, 0, 100, 0, 30, 65536, 46080, 0));
        queue_beat(mk(65536, 0, 0, 65536, 65536, 0, 65536, 11520, 1));
        queue_beat(mk(65536, 0, 0, 65536, 65536, 0, 65536, 11519, 1));
        queue_beat(mk(1, 2, 3, 1, 2, 4, 0, 256, 1));
        queue_beat(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h80000000, 32'h80000000, 32'h80000000, 65536, 46080, 1));
        begin
            target_beat_t e;
            e = mk(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'h80000000, 32'h7fffffff, 32'h80000000, 65536, 65535, 1);
            e.b = '{32'h80000000, 32'h7fffffff, 32'h80000000};
            queue_beat(e);
        end
        for (int i = 0; i < N_RANDOM; i++) queue_beat(random_beat());

        fork
            begin
                repeat (500) @(posedge clk);
                calm = 1;
                repeat (300) @(posedge clk);
                calm = 0;
            end
        join_none
        drive_targets();

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);

        $display("Checked %0d weight beats from %0d target beats (directed and random).",
                 sb.n_checked, stim.size());
        if (n_errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
